### rtl/mpbc_pkg.sv
// Shared types and constants for the multi-point bit crossover.
`timescale 1ns / 1ps
package mpbc_pkg;

    localparam int DEF_MAX_LENGTH = 1024;
    localparam int DEF_MAX_CUTS   = 8;

    localparam int LEN_IN_W  = 11;
    localparam int CUT_IN_W  = 12;
    localparam int IDX_W     = 10;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;
    localparam int CMD_W     = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_CUT   = 2'd1,
        CMD_PAIR  = 2'd2
    } cmd_t;

    // Control part of a request moving down the cell chain
    typedef struct packed {
        cmd_t kind;
        logic taken;       // cut already stored by an earlier cell
        logic parity;      // parity of cuts at or below the position so far
        logic bit_first;
        logic bit_second;
        logic last;
    } ctrl_t;

endpackage

### rtl/multi_point_bit_crossover.sv
// Multi-point bit crossover: front end, chain of cut cells and output register.
// A bit pair is registered in each of the MAX_CUTS cells, then in the output register.
// Throughput: one request per cycle while output is free; the chain is fully pipelined.
// Input is taken while a result waits, until the chain itself fills up behind it.
// Reset (rst_n low, asynchronous) clears length, position, all cut slots and the pipeline.
`timescale 1ns / 1ps
module multi_point_bit_crossover #(
    parameter int MAX_LENGTH = mpbc_pkg::DEF_MAX_LENGTH,
    parameter int MAX_CUTS   = mpbc_pkg::DEF_MAX_CUTS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // common_length[10:0], cut_position[22:11], bit_first[23], bit_second[24], zero pad
    input  logic [mpbc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // command
    input  logic [mpbc_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // child_first[0], child_second[1], bit_index[11:2], zero pad
    output logic [mpbc_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // last_bit
    output logic                             m_axis_tlast
);
    import mpbc_pkg::*;

    localparam int LEN_W = $clog2(MAX_LENGTH + 1);
    localparam int POS_W = $clog2(MAX_LENGTH);

    // ---------------- front end ----------------
    logic [LEN_W-1:0]    string_length_reg;
    logic [LEN_W-1:0]    string_length_next;
    logic [LEN_W-1:0]    next_position_reg;
    logic [LEN_W-1:0]    next_position_next;
    logic [LEN_IN_W-1:0] len_in;
    logic [CUT_IN_W-1:0] cut_in;
    logic [31:0]         cut_mag;
    logic [31:0]         cut_clamped;
    logic                pair_ok;
    logic                accept;
    logic                front_valid;
    ctrl_t               front_ctrl;
    logic [POS_W-1:0]    front_pos;

    logic                chain_valid [0:MAX_CUTS];
    ctrl_t               chain_ctrl  [0:MAX_CUTS];
    logic [POS_W-1:0]    chain_pos   [0:MAX_CUTS];
    logic                chain_ready [0:MAX_CUTS];

    assign len_in  = s_axis_tdata[LEN_IN_W-1:0];
    assign cut_in  = s_axis_tdata[LEN_IN_W+CUT_IN_W-1:LEN_IN_W];
    assign cut_mag = 32'(cut_in[CUT_IN_W-2:0]);
    assign pair_ok = next_position_reg < string_length_reg;
    assign s_axis_tready = chain_ready[0];
    assign accept  = s_axis_tvalid && s_axis_tready;

    assign chain_valid[0] = front_valid;
    assign chain_ctrl[0]  = front_ctrl;
    assign chain_pos[0]   = front_pos;

    always_comb
    begin
        if (cut_in[CUT_IN_W-1] || (string_length_reg == '0))
            cut_clamped = '0;
        else if (cut_mag >= 32'(string_length_reg))
            cut_clamped = 32'(string_length_reg) - 32'd1;
        else
            cut_clamped = cut_mag;
    end

    always_comb
    begin
        string_length_next = string_length_reg;
        next_position_next = next_position_reg;
        front_valid        = 1'b0;
        front_ctrl         = '0;
        front_pos          = '0;
        unique case (s_axis_tuser)
            CMD_START:
            begin
                front_valid     = s_axis_tvalid;
                front_ctrl.kind = CMD_START;
                if (accept)
                begin
                    if (32'(len_in) > MAX_LENGTH)
                        string_length_next = LEN_W'(MAX_LENGTH);
                    else
                        string_length_next = LEN_W'(len_in);
                    next_position_next = '0;
                end
            end
            CMD_CUT:
            begin
                front_valid     = s_axis_tvalid;
                front_ctrl.kind = CMD_CUT;
                front_pos       = POS_W'(cut_clamped);
            end
            CMD_PAIR:
            begin
                front_valid           = s_axis_tvalid && pair_ok;
                front_ctrl.kind       = CMD_PAIR;
                front_ctrl.bit_first  = s_axis_tdata[LEN_IN_W+CUT_IN_W];
                front_ctrl.bit_second = s_axis_tdata[LEN_IN_W+CUT_IN_W+1];
                front_ctrl.last       = (next_position_reg + LEN_W'(1)) == string_length_reg;
                front_pos             = POS_W'(next_position_reg);
                if (accept && pair_ok)
                    next_position_next = next_position_reg + LEN_W'(1);
            end
            default:
            begin
                front_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            string_length_reg <= '0;
            next_position_reg <= '0;
        end
        else
        begin
            string_length_reg <= string_length_next;
            next_position_reg <= next_position_next;
        end
    end

    // ---------------- cell chain ----------------
    for (genvar k = 0; k < MAX_CUTS; k++)
    begin : g_cell
        mpbc_cell #(
            .POS_W (POS_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[k]),
            .in_ctrl   (chain_ctrl[k]),
            .in_pos    (chain_pos[k]),
            .in_ready  (chain_ready[k]),
            .out_valid (chain_valid[k+1]),
            .out_ctrl  (chain_ctrl[k+1]),
            .out_pos   (chain_pos[k+1]),
            .out_ready (chain_ready[k+1])
        );
    end

    // ---------------- output register ----------------
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_first_reg;
    logic             out_second_reg;
    logic [IDX_W-1:0] out_index_reg;
    logic             out_last_reg;
    logic             out_free;
    logic             out_load;
    logic             swap;
    logic [31:0]      pos_wide;

    assign out_free = !out_valid_reg || m_axis_tready;
    // start and cut requests leave the chain here without a result
    assign chain_ready[MAX_CUTS] = (chain_ctrl[MAX_CUTS].kind != CMD_PAIR) || out_free;
    assign out_load = chain_valid[MAX_CUTS] && (chain_ctrl[MAX_CUTS].kind == CMD_PAIR)
                      && out_free;
    // even number of cuts at or below the position means swap
    assign swap     = !chain_ctrl[MAX_CUTS].parity;
    assign pos_wide = 32'(chain_pos[MAX_CUTS]);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_first_reg  <= swap ? chain_ctrl[MAX_CUTS].bit_second
                                   : chain_ctrl[MAX_CUTS].bit_first;
            out_second_reg <= swap ? chain_ctrl[MAX_CUTS].bit_first
                                   : chain_ctrl[MAX_CUTS].bit_second;
            out_index_reg  <= pos_wide[IDX_W-1:0];
            out_last_reg   <= chain_ctrl[MAX_CUTS].last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(M_TDATA_W-IDX_W-2)'(0), out_index_reg, out_second_reg, out_first_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

### rtl/mpbc_cell.sv
// One cell of the chain: holds one cut and updates the running parity.
`timescale 1ns / 1ps
module mpbc_cell #(
    parameter int POS_W = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  mpbc_pkg::ctrl_t   in_ctrl,
    input  logic [POS_W-1:0]  in_pos,
    output logic              in_ready,
    output logic              out_valid,
    output mpbc_pkg::ctrl_t   out_ctrl,
    output logic [POS_W-1:0]  out_pos,
    input  logic              out_ready
);
    import mpbc_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    ctrl_t            ctrl_reg;
    ctrl_t            ctrl_next;
    logic [POS_W-1:0] pos_reg;
    logic             cut_valid_reg;
    logic             cut_valid_next;
    logic [POS_W-1:0] cut_reg;
    logic [POS_W-1:0] cut_next;
    logic             take;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        ctrl_next      = in_ctrl;
        cut_valid_next = cut_valid_reg;
        cut_next       = cut_reg;
        valid_next     = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
            unique case (in_ctrl.kind)
                CMD_START:
                begin
                    cut_valid_next = 1'b0;
                end
                CMD_CUT:
                begin
                    // first empty cell claims the cut
                    if (!in_ctrl.taken && !cut_valid_reg)
                    begin
                        cut_valid_next  = 1'b1;
                        cut_next        = in_pos;
                        ctrl_next.taken = 1'b1;
                    end
                end
                CMD_PAIR:
                begin
                    ctrl_next.parity = in_ctrl.parity ^ (cut_valid_reg && (cut_reg <= in_pos));
                end
                default:
                begin
                    ctrl_next = in_ctrl;
                end
            endcase
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            cut_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            cut_valid_reg <= cut_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cut_reg <= cut_next;
        if (take)
        begin
            ctrl_reg <= ctrl_next;
            pos_reg  <= in_pos;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctrl  = ctrl_reg;
    assign out_pos   = pos_reg;

endmodule

### rtl/mpbc_checker.sv
// Port-level checks for the multi-point bit crossover, bound to the top level.
`timescale 1ns / 1ps
module mpbc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [mpbc_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tlast
);
    import mpbc_pkg::*;

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // input side only backs up behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // no result once reset has been seen at a clock edge
    assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result valid during reset");

    // padding bits above bit_index stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[M_TDATA_W-1:IDX_W+2] == '0)
        else $error("nonzero padding in result");

endmodule

bind multi_point_bit_crossover mpbc_checker u_mpbc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

### test/tb_multi_point_bit_crossover.sv
// Self-checking testbench for the multi-point bit crossover stream block.
`timescale 1ns / 1ps
module tb_multi_point_bit_crossover;
    import mpbc_pkg::*;

    localparam int MAX_LENGTH = DEF_MAX_LENGTH;
    localparam int MAX_CUTS   = DEF_MAX_CUTS;
    localparam int CUT_IDX_W  = $clog2(MAX_CUTS);
    localparam int LATENCY    = DEF_MAX_CUTS + 1;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic             child_first;
        logic             child_second;
        logic [IDX_W-1:0] bit_index;
        logic             last_bit;
    } child_bits_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [CMD_W-1:0]     s_axis_tuser = CMD_START;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;

    // Predicted crossover state
    logic [LEN_IN_W-1:0] run_length = '0;
    logic [IDX_W-1:0]    cut_slots [MAX_CUTS];
    logic [3:0]          cuts_held = '0;
    logic [LEN_IN_W-1:0] bit_pos = '0;

    child_bits_t pending_children [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int mismatch_count = 0;
    int results_seen   = 0;
    int requests_sent  = 0;
    int starts_sent    = 0;
    int cuts_sent      = 0;
    int pairs_sent     = 0;

    multi_point_bit_crossover #(
        .MAX_LENGTH(MAX_LENGTH),
        .MAX_CUTS  (MAX_CUTS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void predict_crossover(input logic [CMD_W-1:0] cmd,
                                              input logic [LEN_IN_W-1:0] len_in,
                                              input logic [CUT_IN_W-1:0] cut_in,
                                              input logic bf, input logic bs);
        int          below;
        logic        swap;
        child_bits_t r;
        case (cmd)
            CMD_START:
            begin
                run_length = (int'(len_in) > MAX_LENGTH) ? LEN_IN_W'(MAX_LENGTH) : len_in;
                cuts_held  = '0;
                bit_pos    = '0;
            end
            CMD_CUT:
            begin
                if (cuts_held < MAX_CUTS)
                begin
                    if (cut_in[CUT_IN_W-1] || run_length == 0)
                        cut_slots[CUT_IDX_W'(cuts_held)] = '0;
                    else if (cut_in >= CUT_IN_W'(run_length))
                        cut_slots[CUT_IDX_W'(cuts_held)] = IDX_W'(run_length - 1);
                    else
                        cut_slots[CUT_IDX_W'(cuts_held)] = cut_in[IDX_W-1:0];
                    cuts_held = cuts_held + 4'd1;
                end
            end
            CMD_PAIR:
            begin
                if (bit_pos < run_length)
                begin
                    below = 0;
                    for (int i = 0; i < MAX_CUTS; i++)
                        if (i < cuts_held && LEN_IN_W'(cut_slots[i]) <= bit_pos)
                            below++;
                    // even count at or below the position means the pair is swapped
                    swap           = (below % 2) == 0;
                    r.child_first  = swap ? bs : bf;
                    r.child_second = swap ? bf : bs;
                    r.bit_index    = bit_pos[IDX_W-1:0];
                    r.last_bit     = (bit_pos + 1 == run_length);
                    pending_children.push_back(r);
                    bit_pos = bit_pos + LEN_IN_W'(1);
                end
            end
            default: ;
        endcase
    endfunction

    // Offer one request from the falling edge and hold it until accepted.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [LEN_IN_W-1:0] len,
                                input logic [CUT_IN_W-1:0] cut, input logic [1:0] bits);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {7'd0, bits[1], bits[0], cut, len};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_crossover(cmd, len, cut, bits[0], bits[1]);
        requests_sent++;
        case (cmd)
            CMD_START: starts_sent++;
            CMD_CUT:   cuts_sent++;
            CMD_PAIR:  pairs_sent++;
            default: ;
        endcase
    endtask

    task automatic start_run(input logic [LEN_IN_W-1:0] len);
        send_request(CMD_START, len, CUT_IN_W'($urandom), 2'($urandom));
    endtask

    task automatic add_cut(input logic [CUT_IN_W-1:0] cut);
        send_request(CMD_CUT, LEN_IN_W'($urandom), cut, 2'($urandom));
    endtask

    // bits: bit_first in [0], bit_second in [1]
    task automatic send_pair(input logic [1:0] bits);
        send_request(CMD_PAIR, LEN_IN_W'($urandom), CUT_IN_W'($urandom), bits);
    endtask

    // Sender pauses until every predicted bit is out, then lets the pipe settle.
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_children.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic run_crossover_sequence(input int max_len);
        int len;
        int eff_len;
        int ncuts;
        int npairs;
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)
            len = 0;
        else if (pick < 10)
            len = $urandom_range(2047);
        else
            len = $urandom_range(max_len, 1);
        eff_len = (len > MAX_LENGTH) ? MAX_LENGTH : len;
        start_run(LEN_IN_W'(len));
        ncuts = $urandom_range(MAX_CUTS + 3);
        for (int i = 0; i < ncuts; i++)
        begin
            if ($urandom_range(9) == 0)
                add_cut(CUT_IN_W'($urandom));
            else
                add_cut(CUT_IN_W'($urandom_range(eff_len + 2)));
        end
        npairs = (eff_len <= 64) ? eff_len + $urandom_range(2) : $urandom_range(40, 1);
        for (int i = 0; i < npairs; i++)
        begin
            // occasional stray request in the middle of the stream
            if ($urandom_range(49) == 0)
                send_request(CMD_W'($urandom), LEN_IN_W'($urandom), CUT_IN_W'($urandom),
                             2'($urandom));
            send_pair(2'($urandom));
        end
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_pair(2'b01);               // no run started yet
        send_request(CMD_UNUSED, '1, '1, 2'b11);
        start_run(11'd0);               // empty run: cut clamps to 0, pair gives nothing
        add_cut(12'h7FF);
        send_pair(2'b11);
        start_run(11'h7FF);             // saturates to the maximum length
        add_cut(12'h7FF);
        add_cut(12'h800);
        send_pair(2'b01);
        send_pair(2'b10);
        start_run(11'd4);               // nine cuts, the last one dropped
        add_cut(12'd0);
        add_cut(12'd3);
        add_cut(12'd1);
        add_cut(12'd1);
        add_cut(12'hFFF);
        add_cut(12'd2);
        add_cut(12'd5);
        add_cut(12'd2);
        add_cut(12'd1);
        send_pair(2'b00);
        send_pair(2'b01);
        send_pair(2'b10);
        send_pair(2'b11);
        send_pair(2'b01);               // past the end
        wait_drained();
    endtask

    // One long run that reaches the upper bit_index bits, plus pairs past the end.
    task automatic test_long_run();
        int run_len;
        run_len        = 520;
        send_idle_pct  = 0;
        recv_stall_pct = 21;
        start_run(LEN_IN_W'(run_len));
        for (int i = 0; i < MAX_CUTS; i++)
            add_cut(CUT_IN_W'($urandom_range(run_len - 1)));
        for (int i = 0; i < run_len + 2; i++)
            send_pair(2'($urandom));
        wait_drained();
    endtask

    task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int items);
        int target;
        send_idle_pct  = snd_pct;
        recv_stall_pct = rcv_pct;
        target = requests_sent + items;
        while (requests_sent < target)
            run_crossover_sequence(24);
        wait_drained();
    endtask

    // Receiver holds off while the sender keeps pushing, so the chain fills and stalls.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 300;
        start_run(11'd60);
        add_cut(12'd7);
        add_cut(12'd31);
        add_cut(12'd45);
        for (int i = 0; i < 60; i++)
            send_pair(2'($urandom));
        wait_drained();
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left     = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : check_children
        child_bits_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pending_children.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: tdata=%h tlast=%b",
                             m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                want = pending_children.pop_front();
                if (m_axis_tdata[0] !== want.child_first
                    || m_axis_tdata[1] !== want.child_second
                    || m_axis_tdata[2 +: IDX_W] !== want.bit_index
                    || m_axis_tdata[M_TDATA_W-1:IDX_W+2] !== '0
                    || m_axis_tlast !== want.last_bit)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $write("mismatch: exp c1=%b c2=%b idx=%0d last=%b, ",
                               want.child_first, want.child_second, want.bit_index,
                               want.last_bit);
                        $display("got c1=%b c2=%b idx=%0d last=%b pad=%h",
                                 m_axis_tdata[0], m_axis_tdata[1],
                                 m_axis_tdata[2 +: IDX_W], m_axis_tlast,
                                 m_axis_tdata[M_TDATA_W-1:IDX_W+2]);
                    end
                end
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_long_run();
        test_random_traffic(0, 0, 120);
        test_random_traffic(83, 0, 120);
        test_random_traffic(0, 83, 120);
        test_random_traffic(21, 21, 120);
        test_backpressure();
        wait_drained();

        $write("covered %0d requests (%0d starts, %0d cuts, %0d pairs), ",
               requests_sent, starts_sent, cuts_sent, pairs_sent);
        $display("%0d result bits checked", results_seen);
        $display("idle mixes: none, sender, receiver, both; plus a long receiver hold-off");
        if (mismatch_count == 0 && pending_children.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### multi_point_bit_crossover.f
rtl/mpbc_pkg.sv
rtl/mpbc_cell.sv
rtl/multi_point_bit_crossover.sv
rtl/mpbc_checker.sv
test/tb_multi_point_bit_crossover.sv
